// ===== src/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
package spq_pkg;

    localparam int HELD_BITS = 5;

    typedef logic [1:0] t_status;

    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_FULL  = 2'd1;
    localparam t_status STATUS_EMPTY = 2'd2;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    typedef struct packed {
        logic enq;
        logic deq;
    } t_cell_op;

endpackage

// ===== src/spq_req_if.sv =====
// Request channel: one command word with its priority and tag.
interface spq_req_if import spq_pkg::*; #(
    parameter int PRIO_BITS = 8,
    parameter int TAG_BITS  = 16
);
    logic                 valid;
    logic                 ready;
    logic                 cmd;
    logic [PRIO_BITS-1:0] prio;
    logic [TAG_BITS-1:0]  tag_in;

    modport source (output valid, output cmd, output prio, output tag_in, input ready);
    modport sink   (input valid, input cmd, input prio, input tag_in, output ready);
endinterface

// ===== src/spq_rsp_if.sv =====
// Response channel: status, dequeued tag and fill level after each command.
interface spq_rsp_if import spq_pkg::*; #(
    parameter int TAG_BITS = 16
);
    logic                 valid;
    logic                 ready;
    t_status              status;
    logic [TAG_BITS-1:0]  tag_out;
    logic [HELD_BITS-1:0] held_after;

    modport source (output valid, output status, output tag_out, output held_after,
                    input ready);
    modport sink   (input valid, input status, input tag_out, input held_after,
                    output ready);
endinterface

// ===== src/spq_cell.sv =====
// One slot of the sorted row: holds an entry and shifts toward either neighbor.
module spq_cell import spq_pkg::*; #(
    parameter int PRIO_BITS = 8,
    parameter int TAG_BITS  = 16
) (
    input  logic                 i_clk,
    input  t_cell_op             i_op,
    input  logic                 i_occ,
    input  logic [PRIO_BITS-1:0] i_new_prio,
    input  logic [TAG_BITS-1:0]  i_new_tag,
    input  logic                 i_left_ge,
    input  logic [PRIO_BITS-1:0] i_left_prio,
    input  logic [TAG_BITS-1:0]  i_left_tag,
    input  logic [PRIO_BITS-1:0] i_right_prio,
    input  logic [TAG_BITS-1:0]  i_right_tag,
    output logic                 o_ge,
    output logic [PRIO_BITS-1:0] o_prio,
    output logic [TAG_BITS-1:0]  o_tag
);
    logic [PRIO_BITS-1:0] r_prio;
    logic [TAG_BITS-1:0]  r_tag;

    // The held entries that outrank or tie the new one form a prefix of the row.
    assign o_ge   = i_occ && (r_prio >= i_new_prio);
    assign o_prio = r_prio;
    assign o_tag  = r_tag;

    always_ff @(posedge i_clk) begin
        if (i_op.enq && !o_ge) begin
            // The first cell past the prefix takes the new entry; the rest shift back.
            if (i_left_ge) begin
                r_prio <= i_new_prio;
                r_tag  <= i_new_tag;
            end else begin
                r_prio <= i_left_prio;
                r_tag  <= i_left_tag;
            end
        end else if (i_op.deq) begin
            r_prio <= i_right_prio;
            r_tag  <= i_right_tag;
        end
    end

endmodule

// ===== src/spq_obuf.sv =====
// Two-word response buffer so that a stalled receiver does not stop intake at once.
module spq_obuf import spq_pkg::*; #(
    parameter int TAG_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  t_status              i_status,
    input  logic [TAG_BITS-1:0]  i_tag,
    input  logic [HELD_BITS-1:0] i_held,
    output logic                 o_ready,
    spq_rsp_if.source            o_rsp
);
    logic                 r_vld0;
    logic                 r_vld1;
    t_status              r_status0;
    t_status              r_status1;
    logic [TAG_BITS-1:0]  r_tag0;
    logic [TAG_BITS-1:0]  r_tag1;
    logic [HELD_BITS-1:0] r_held0;
    logic [HELD_BITS-1:0] r_held1;
    logic                 w_pop;

    assign w_pop            = r_vld0 && o_rsp.ready;
    assign o_ready          = !r_vld1;
    assign o_rsp.valid      = r_vld0;
    assign o_rsp.status     = r_status0;
    assign o_rsp.tag_out    = r_tag0;
    assign o_rsp.held_after = r_held0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            r_vld1 <= 1'b0;
        end else begin
            if (w_pop && r_vld1) begin
                r_vld1 <= i_push;
            end else if (w_pop) begin
                r_vld0 <= i_push;
            end else if (i_push && !r_vld0) begin
                r_vld0 <= 1'b1;
            end else if (i_push) begin
                r_vld1 <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && r_vld1) begin
            r_status0 <= r_status1;
            r_tag0    <= r_tag1;
            r_held0   <= r_held1;
            if (i_push) begin
                r_status1 <= i_status;
                r_tag1    <= i_tag;
                r_held1   <= i_held;
            end
        end else if ((w_pop || !r_vld0) && i_push) begin
            r_status0 <= i_status;
            r_tag0    <= i_tag;
            r_held0   <= i_held;
        end else if (i_push) begin
            r_status1 <= i_status;
            r_tag1    <= i_tag;
            r_held1   <= i_held;
        end
    end

endmodule

// ===== src/sorted_priority_queue.sv =====
// Sorted priority queue built as a row of shifting entry cells.
//
// Requests arrive on i_req: cmd selects enqueue (prio, tag_in) or dequeue.
// Every request word yields exactly one response word on o_rsp carrying
// status (ok, full, empty), the dequeued tag (zero otherwise) and the
// number of entries held after the request.
// Entries are kept sorted with the highest priority in cell zero; an
// enqueue lands behind all entries of greater or equal priority, so equal
// priorities leave in arrival order. An enqueue to a full queue is dropped
// and a dequeue from an empty queue reports empty; neither changes state.
// One request word is taken per cycle while the response buffer has room:
// every cell compares against the new priority in parallel and the whole
// row shifts in the same cycle, so the next request already sees the
// updated order. Each response is registered in the response buffer.
// Reset empties the queue and the response buffer; entry contents are not
// cleared. The two-word response buffer lets one more request in while the
// receiver stalls; after that i_req.ready stays low until o_rsp drains.
module sorted_priority_queue import spq_pkg::*; #(
    parameter int DEPTH     = 16,
    parameter int PRIO_BITS = 8,
    parameter int TAG_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spq_req_if.sink     i_req,
    spq_rsp_if.source   o_rsp
);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 w_acc;
    logic                 w_is_enq;
    logic                 w_full;
    logic                 w_empty;
    logic                 w_buf_ready;
    t_cell_op             w_op;
    t_status              w_status;
    logic [TAG_BITS-1:0]  w_tag_out;
    logic [PRIO_BITS-1:0] w_prio [DEPTH];
    logic [TAG_BITS-1:0]  w_tag  [DEPTH];
    logic                 w_ge   [DEPTH];

    assign i_req.ready = w_buf_ready;
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_is_enq    = (i_req.cmd == CMD_ENQ);
    assign w_full      = (r_count == CNT_W'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_op.enq    = w_acc && w_is_enq && !w_full;
    assign w_op.deq    = w_acc && !w_is_enq && !w_empty;

    always_comb begin
        n_count   = r_count;
        w_status  = STATUS_OK;
        w_tag_out = '0;
        if (w_is_enq) begin
            if (w_full) begin
                w_status = STATUS_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (w_empty) begin
                w_status = STATUS_EMPTY;
            end else begin
                n_count   = r_count - 1'b1;
                w_tag_out = w_tag[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_acc) begin
            r_count <= n_count;
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                 w_left_ge;
        logic [PRIO_BITS-1:0] w_left_prio;
        logic [TAG_BITS-1:0]  w_left_tag;
        logic [PRIO_BITS-1:0] w_right_prio;
        logic [TAG_BITS-1:0]  w_right_tag;

        if (g == 0) begin : g_head
            assign w_left_ge   = 1'b1;
            assign w_left_prio = i_req.prio;
            assign w_left_tag  = i_req.tag_in;
        end else begin : g_body
            assign w_left_ge   = w_ge[g-1];
            assign w_left_prio = w_prio[g-1];
            assign w_left_tag  = w_tag[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right_prio = w_prio[g];
            assign w_right_tag  = w_tag[g];
        end else begin : g_inner
            assign w_right_prio = w_prio[g+1];
            assign w_right_tag  = w_tag[g+1];
        end

        spq_cell #(
            .PRIO_BITS (PRIO_BITS),
            .TAG_BITS  (TAG_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_op         (w_op),
            .i_occ        (CNT_W'(g) < r_count),
            .i_new_prio   (i_req.prio),
            .i_new_tag    (i_req.tag_in),
            .i_left_ge    (w_left_ge),
            .i_left_prio  (w_left_prio),
            .i_left_tag   (w_left_tag),
            .i_right_prio (w_right_prio),
            .i_right_tag  (w_right_tag),
            .o_ge         (w_ge[g]),
            .o_prio       (w_prio[g]),
            .o_tag        (w_tag[g])
        );
    end

    spq_obuf #(
        .TAG_BITS (TAG_BITS)
    ) u_obuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_acc),
        .i_status (w_status),
        .i_tag    (w_tag_out),
        .i_held   (HELD_BITS'(n_count)),
        .o_ready  (w_buf_ready),
        .o_rsp    (o_rsp)
    );

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_enq_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_op.enq |=> r_count == $past(r_count) + 1'b1)
        else $error("accepted enqueue did not add an entry");

    a_deq_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_op.deq |=> r_count == $past(r_count) - 1'b1)
        else $error("accepted dequeue did not remove an entry");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (w_prio[0] >= w_prio[1]))
        else $error("head entry outranked by its successor");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_is_enq && w_full) |=> $stable(r_count))
        else $error("enqueue to a full queue changed the count");
`endif

endmodule

// ===== verif/sorted_priority_queue_tb.sv =====
// Self-checking testbench for the sorted priority queue with a scoreboard of expected replies.

class spq_scoreboard;
    localparam int SLOTS = 16;

    typedef struct {
        spq_pkg::t_status status;
        logic [15:0]      tag_out;
        logic [4:0]       held_after;
    } t_reply;

    logic [7:0]  slot_prio [SLOTS];
    logic [15:0] slot_tag  [SLOTS];
    int          held;
    t_reply      replies_due [$];
    int          fault_count;

    function new();
        held        = 0;
        fault_count = 0;
    endfunction

    // Mirrors the queue on every accepted request word and queues the reply it must cause.
    function void note_request(logic cmd, logic [7:0] prio, logic [15:0] tag);
        t_reply r;
        int     pos;
        int     k;
        r.status  = spq_pkg::STATUS_OK;
        r.tag_out = '0;
        if (cmd == spq_pkg::CMD_ENQ) begin
            if (held >= SLOTS) begin
                r.status = spq_pkg::STATUS_FULL;
            end else begin
                // New entry goes behind every entry of equal or higher priority.
                pos = 0;
                while (pos < held && slot_prio[pos] >= prio) pos++;
                for (k = held; k > pos; k--) begin
                    slot_prio[k] = slot_prio[k-1];
                    slot_tag[k]  = slot_tag[k-1];
                end
                slot_prio[pos] = prio;
                slot_tag[pos]  = tag;
                held++;
            end
        end else begin
            if (held == 0) begin
                r.status = spq_pkg::STATUS_EMPTY;
            end else begin
                r.tag_out = slot_tag[0];
                for (k = 1; k < held; k++) begin
                    slot_prio[k-1] = slot_prio[k];
                    slot_tag[k-1]  = slot_tag[k];
                end
                held--;
            end
        end
        r.held_after = 5'(held);
        replies_due.push_back(r);
    endfunction

    task report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d, want %0d", what, got, want);
        fault_count++;
    endtask

    task check_reply(spq_pkg::t_status status, logic [15:0] tag_out, logic [4:0] held_after);
        t_reply r;
        if (replies_due.size() == 0) begin
            report_mismatch("unexpected response word", 1, 0);
        end else begin
            r = replies_due.pop_front();
            if (status !== r.status)
                report_mismatch("status", int'(status), int'(r.status));
            if (tag_out !== r.tag_out)
                report_mismatch("tag_out", int'(tag_out), int'(r.tag_out));
            if (held_after !== r.held_after)
                report_mismatch("held_after", int'(held_after), int'(r.held_after));
        end
    endtask
endclass

module sorted_priority_queue_tb;
    import spq_pkg::*;

    localparam int ITEM_TARGET = 650;
    localparam int HOLD_CYCLES = 80;
    localparam int IDLE_LIMIT  = 2000;

    logic i_clk;
    logic i_rst_n;
    int   words_sent;
    int   idle_cycles;
    bit   req_smooth;

    spq_scoreboard sb = new();

    spq_req_if #(.PRIO_BITS(8), .TAG_BITS(16)) req_ch ();
    spq_rsp_if #(.TAG_BITS(16))                rsp_ch ();

    sorted_priority_queue #(
        .DEPTH     (16),
        .PRIO_BITS (8),
        .TAG_BITS  (16)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    task automatic send_word(input logic cmd, input logic [7:0] prio, input logic [15:0] tag);
        int gap;
        gap = req_smooth ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.cmd    <= cmd;
        req_ch.prio   <= prio;
        req_ch.tag_in <= tag;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        sb.note_request(cmd, prio, tag);
        words_sent++;
    endtask

    task automatic run_directed();
        int i;
        send_word(CMD_DEQ, 8'd0, 16'h0000);
        send_word(CMD_ENQ, 8'd255, 16'hFFFF);
        send_word(CMD_ENQ, 8'd128, 16'h0001);
        send_word(CMD_ENQ, 8'd128, 16'h0002);
        send_word(CMD_ENQ, 8'd0, 16'h0000);
        repeat (4) send_word(CMD_DEQ, 8'hFF, 16'hFFFF);
        send_word(CMD_DEQ, 8'd0, 16'h0000);
        // Rising priorities make every insert land at the head and shift the whole row.
        for (i = 0; i < 16; i++)
            send_word(CMD_ENQ, 8'(i * 17), 16'(16'hA500 + i));
        send_word(CMD_ENQ, 8'd255, 16'h5A5A);
    endtask

    task automatic run_random();
        int          burst_len;
        int          pick;
        int          enq_pct;
        bit          narrow;
        logic        cmd;
        logic [7:0]  prio;
        logic [15:0] tag;
        while (words_sent < ITEM_TARGET) begin
            burst_len  = $urandom_range(20, 50);
            pick       = $urandom_range(0, 9);
            enq_pct    = (pick < 3) ? 85 : ((pick < 6) ? 15 : 55);
            narrow     = 1'($urandom_range(0, 1));
            req_smooth = ($urandom_range(0, 3) == 0);
            repeat (burst_len) begin
                cmd  = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
                // A narrow priority range produces many ties to exercise arrival order.
                prio = narrow ? 8'($urandom_range(0, 3)) : 8'($urandom);
                tag  = 16'($urandom);
                send_word(cmd, prio, tag);
            end
        end
    endtask

    initial begin
        req_ch.valid  = 1'b0;
        req_ch.cmd    = CMD_ENQ;
        req_ch.prio   = '0;
        req_ch.tag_in = '0;
        i_rst_n       = 1'b0;
        words_sent    = 0;
        req_smooth    = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random();
        req_ch.valid <= 1'b0;
        while (sb.replies_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.fault_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        int stall;
        int taken;
        bit smooth;
        rsp_ch.ready = 1'b0;
        taken        = 0;
        smooth       = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (taken % 40 == 0)
                smooth = ($urandom_range(0, 3) == 0);
            // Long holds let the response buffer fill so the block must stall its input.
            if (taken == 60 || taken == 300)
                stall = HOLD_CYCLES;
            else
                stall = smooth ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (rsp_ch.valid !== 1'b1) @(posedge i_clk);
            sb.check_reply(rsp_ch.status, rsp_ch.tag_out, rsp_ch.held_after);
            taken++;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
                || (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial idle_cycles = 0;

endmodule
